FILE: sv/assert_macros.svh
// assertion macros used by the extractor core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define BSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked also across reset
`define BSE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: sv/bse_pkg.sv
// types and constants for the beacon ssid extractor
package bse_pkg;

    localparam int NAME_DEPTH     = 32;
    localparam int NAME_IDX_W     = 5;
    localparam int NAME_LEN_W     = 6;
    localparam int BSSID_W        = 48;

    localparam int HDR_LEN_LO_POS = 2;
    localparam int HDR_LEN_HI_POS = 3;
    localparam int HDR_LEN_MIN    = 4;
    localparam int BSSID_FIRST    = 16;
    localparam int BSSID_LAST     = 21;
    localparam int ELEMENTS_START = 36;

    localparam logic [1:0] MGMT_TYPE      = 2'h0;
    localparam logic [3:0] BEACON_SUBTYPE = 4'h8;
    localparam logic [7:0] SSID_ELEMENT   = 8'h00;

    typedef struct packed {
        logic                  en;
        logic [NAME_IDX_W-1:0] addr;
        logic [7:0]            data;
    } bse_name_wr_t;

    typedef struct packed {
        logic                  valid;
        logic [NAME_LEN_W-1:0] len;
    } bse_done_t;

endpackage

FILE: sv/beacon_ssid_extractor_core.sv
// beacon ssid extractor: parses one captured byte a cycle while s_ready is high, bursts out the name
// after the last ssid byte is taken, the emit state register is set and then the first name character
// is loaded into the output register, once that register is empty or being drained
// throughput: one input word per cycle while parsing; one name character per cycle out while m_ready is high
// input is held off (s_ready low) while the name is read out, including m_ready stalls
// aresetn is synchronous and active low; it clears parser state and output valid
module beacon_ssid_extractor_core #(
    parameter int MAX_NAME_LEN   = 32,
    parameter int POSITION_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_of_frame,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_ssid_char,
    output logic [4:0]  m_char_index,
    output logic [5:0]  m_ssid_length,
    output logic [47:0] m_bssid,
    output logic        m_last
);
    import bse_pkg::*;

    `include "assert_macros.svh"

    bse_name_wr_t name_wr;
    bse_done_t    done;
    logic [47:0]  bssid;
    logic         accept;

    logic [7:0]            name_buf [NAME_DEPTH];
    logic                  emit_active_reg;
    logic [NAME_IDX_W-1:0] emit_idx_reg;
    logic [NAME_LEN_W-1:0] emit_len_reg;
    logic [NAME_LEN_W-1:0] idx_inc;
    logic                  emit_last;
    logic                  load;

    logic                  m_valid_reg;
    logic [7:0]            char_reg;
    logic [NAME_IDX_W-1:0] index_reg;
    logic [NAME_LEN_W-1:0] length_reg;
    logic [47:0]           bssid_reg;
    logic                  last_reg;

    assign s_ready = !emit_active_reg;
    assign accept  = s_valid && s_ready;

    bse_parser #(
        .MAX_NAME_LEN  (MAX_NAME_LEN),
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .data_byte     (s_data_byte),
        .start_of_frame(s_start_of_frame),
        .name_wr       (name_wr),
        .done          (done),
        .bssid         (bssid)
    );

    always_ff @(posedge aclk) begin
        if (name_wr.en) begin
            name_buf[name_wr.addr] <= name_wr.data;
        end
    end

    assign idx_inc   = {1'b0, emit_idx_reg} + NAME_LEN_W'(1);
    assign emit_last = (idx_inc == emit_len_reg);
    // output register refills when empty or being drained
    assign load      = emit_active_reg && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_active_reg <= 1'b0;
            emit_idx_reg    <= '0;
            emit_len_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (done.valid) begin
                emit_active_reg <= 1'b1;
                emit_idx_reg    <= '0;
                emit_len_reg    <= done.len;
            end else if (load) begin
                emit_idx_reg <= idx_inc[NAME_IDX_W-1:0];
                if (emit_last) begin
                    emit_active_reg <= 1'b0;
                end
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            char_reg   <= name_buf[emit_idx_reg];
            index_reg  <= emit_idx_reg;
            length_reg <= emit_len_reg;
            bssid_reg  <= bssid;
            last_reg   <= emit_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_ssid_char   = char_reg;
    assign m_char_index  = index_reg;
    assign m_ssid_length = length_reg;
    assign m_bssid       = bssid_reg;
    assign m_last        = last_reg;

    `BSE_ASSERT(a_index_steps, (m_valid && m_ready && !m_last) |=> (m_valid && m_char_index == 5'($past(m_char_index) + 5'd1)), "name index did not step")
    `BSE_ASSERT(a_last_matches_len, m_valid |-> (m_last == ((6'(m_char_index) + 6'd1) == m_ssid_length)), "last flag disagrees with length")
    `BSE_ASSERT(a_no_input_mid_name, (m_valid && !m_last) |-> !s_ready, "input taken during name burst")
    `BSE_ASSERT_RST(a_reset_clears_valid, !aresetn |=> !m_valid, "output valid after reset")

endmodule

FILE: sv/bse_parser.sv
// frame parser: radiotap skip, beacon check, bssid capture, element walk
module bse_parser #(
    parameter int MAX_NAME_LEN   = 32,
    parameter int POSITION_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  start_of_frame,
    output bse_pkg::bse_name_wr_t name_wr,
    output bse_pkg::bse_done_t    done,
    output logic [47:0]           bssid
);
    import bse_pkg::*;

    localparam int PW  = POSITION_WIDTH;
    localparam int PW1 = POSITION_WIDTH + 1;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HEADER, PH_MAC, PH_ELEM_ID, PH_ELEM_LEN, PH_ELEM_BODY
    } phase_t;

    phase_t        phase_reg, phase_next, phase_c;
    logic [PW-1:0] pos_reg, pos_next, pos_c;
    logic [PW1-1:0] pos_inc;
    logic [15:0]   hdr_reg, hdr_next, hdr_c;
    logic [47:0]   bssid_reg, bssid_next, bssid_c;
    logic [7:0]    eid_reg, eid_next, eid_c;
    logic [7:0]    rem_reg, rem_next, rem_c, rem_dec;
    logic          nf_reg, nf_next, nf_c;

    always_comb begin
        // a frame start restarts parsing on this word
        phase_c = start_of_frame ? PH_HEADER : phase_reg;
        pos_c   = start_of_frame ? '0 : pos_reg;
        hdr_c   = start_of_frame ? '0 : hdr_reg;
        bssid_c = start_of_frame ? '0 : bssid_reg;
        eid_c   = start_of_frame ? '0 : eid_reg;
        rem_c   = start_of_frame ? '0 : rem_reg;
        nf_c    = start_of_frame ? 1'b0 : nf_reg;

        pos_inc = {1'b0, pos_c} + PW1'(1);
        rem_dec = rem_c - 8'd1;

        phase_next = phase_c;
        pos_next   = pos_c;
        hdr_next   = hdr_c;
        bssid_next = bssid_c;
        eid_next   = eid_c;
        rem_next   = rem_c;
        nf_next    = nf_c;
        name_wr    = '0;
        done       = '0;

        unique case (phase_c)
            PH_HEADER: begin
                if (pos_c == PW'(HDR_LEN_LO_POS)) begin
                    hdr_next = {hdr_c[15:8], data_byte};
                end else if (pos_c == PW'(HDR_LEN_HI_POS)) begin
                    hdr_next = {data_byte, hdr_c[7:0]};
                end
                if (pos_c >= PW'(HDR_LEN_HI_POS)) begin
                    if (hdr_next < 16'(HDR_LEN_MIN) || (hdr_next >> PW) != 16'd0) begin
                        phase_next = PH_IDLE;
                    end else if (pos_inc == PW1'(hdr_next)) begin
                        phase_next = PH_MAC;
                        pos_next   = '0;
                    end else begin
                        pos_next = pos_inc[PW-1:0];
                    end
                end else begin
                    pos_next = pos_inc[PW-1:0];
                end
            end
            PH_MAC: begin
                if (pos_c == '0 &&
                    (data_byte[3:2] != MGMT_TYPE || data_byte[7:4] != BEACON_SUBTYPE)) begin
                    phase_next = PH_IDLE;
                end else begin
                    if (pos_c >= PW'(BSSID_FIRST) && pos_c <= PW'(BSSID_LAST)) begin
                        bssid_next = {bssid_c[39:0], data_byte};
                    end
                    if (pos_inc == PW1'(ELEMENTS_START)) begin
                        phase_next = PH_ELEM_ID;
                        pos_next   = '0;
                    end else begin
                        pos_next = pos_inc[PW-1:0];
                    end
                end
            end
            PH_ELEM_ID: begin
                eid_next   = data_byte;
                phase_next = PH_ELEM_LEN;
            end
            PH_ELEM_LEN: begin
                rem_next   = data_byte;
                pos_next   = '0;
                nf_next    = (eid_c == SSID_ELEMENT) && (data_byte != 8'd0) &&
                             (data_byte <= 8'(MAX_NAME_LEN));
                phase_next = (data_byte == 8'd0) ? PH_ELEM_ID : PH_ELEM_BODY;
            end
            PH_ELEM_BODY: begin
                name_wr.en   = nf_c;
                name_wr.addr = pos_c[NAME_IDX_W-1:0];
                name_wr.data = data_byte;
                pos_next     = pos_inc[PW-1:0];
                rem_next     = rem_dec;
                if (rem_dec == 8'd0) begin
                    if (nf_c) begin
                        // name bytes never exceed the name limit here
                        done.valid = 1'b1;
                        done.len   = pos_inc[NAME_LEN_W-1:0];
                        nf_next    = 1'b0;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_ELEM_ID;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        if (!accept) begin
            name_wr = '0;
            done    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            hdr_reg   <= '0;
            bssid_reg <= '0;
            eid_reg   <= '0;
            rem_reg   <= '0;
            nf_reg    <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            hdr_reg   <= hdr_next;
            bssid_reg <= bssid_next;
            eid_reg   <= eid_next;
            rem_reg   <= rem_next;
            nf_reg    <= nf_next;
        end
    end

    assign bssid = bssid_reg;

endmodule

FILE: verif/bse_name_checker.sv
// checker for the beacon ssid extractor: follows the input words, predicts and compares names
module bse_name_checker #(
    parameter int MAX_NAME_LEN   = 32,
    parameter int POSITION_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_of_frame,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_ssid_char,
    input  logic [4:0]  m_char_index,
    input  logic [5:0]  m_ssid_length,
    input  logic [47:0] m_bssid,
    input  logic        m_last,
    output int          mismatch_count,
    output int          chars_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import bse_pkg::*;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_RADIOTAP,
        SCAN_MAC,
        SCAN_ELEM_ID,
        SCAN_ELEM_LEN,
        SCAN_ELEM_BODY
    } scan_phase_e;

    typedef struct packed {
        logic [7:0]            ch;
        logic [NAME_IDX_W-1:0] idx;
        logic [NAME_LEN_W-1:0] len;
        logic [BSSID_W-1:0]    bssid;
        logic                  last;
    } name_char_t;

    localparam int POS_LIMIT = (1 << POSITION_WIDTH) - 1;

    scan_phase_e               phase;
    logic [POSITION_WIDTH-1:0] pos;
    logic [15:0]               hdr_len_acc;
    logic [BSSID_W-1:0]        bssid_acc;
    logic [7:0]                elem_id;
    logic [7:0]                elem_left;
    logic                      name_on;
    logic [7:0]                name_mem [NAME_DEPTH];
    name_char_t                name_chars_due [$];
    int                        mismatches = 0;

    assign mismatch_count = mismatches;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t: %s got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic sof);
        int         n;
        name_char_t c;
        if (sof) begin
            pos         = '0;
            hdr_len_acc = '0;
            bssid_acc   = '0;
            elem_id     = '0;
            elem_left   = '0;
            name_on     = 1'b0;
            phase       = SCAN_RADIOTAP;
        end
        case (phase)
            SCAN_RADIOTAP: begin
                if (pos == HDR_LEN_LO_POS)
                    hdr_len_acc[7:0] = b;
                else if (pos == HDR_LEN_HI_POS)
                    hdr_len_acc[15:8] = b;
                if (pos >= HDR_LEN_HI_POS) begin
                    if (hdr_len_acc < HDR_LEN_MIN || int'(hdr_len_acc) > POS_LIMIT) begin
                        phase = SCAN_IDLE;
                    end else if (int'(pos) + 1 == int'(hdr_len_acc)) begin
                        phase = SCAN_MAC;
                        pos   = '0;
                    end else begin
                        pos = pos + 1'b1;
                    end
                end else begin
                    pos = pos + 1'b1;
                end
            end
            SCAN_MAC: begin
                // frame control low byte decides whether this is a beacon
                if (pos == 0 && (b[3:2] != MGMT_TYPE || b[7:4] != BEACON_SUBTYPE)) begin
                    phase = SCAN_IDLE;
                end else begin
                    if (pos >= BSSID_FIRST && pos <= BSSID_LAST)
                        bssid_acc = {bssid_acc[BSSID_W-9:0], b};
                    if (int'(pos) + 1 == ELEMENTS_START) begin
                        phase = SCAN_ELEM_ID;
                        pos   = '0;
                    end else begin
                        pos = pos + 1'b1;
                    end
                end
            end
            SCAN_ELEM_ID: begin
                elem_id = b;
                phase   = SCAN_ELEM_LEN;
            end
            SCAN_ELEM_LEN: begin
                elem_left = b;
                pos       = '0;
                name_on   = (elem_id == SSID_ELEMENT && b >= 1 && b <= MAX_NAME_LEN);
                phase     = (b == 0) ? SCAN_ELEM_ID : SCAN_ELEM_BODY;
            end
            SCAN_ELEM_BODY: begin
                if (name_on)
                    name_mem[pos[NAME_IDX_W-1:0]] = b;
                pos       = pos + 1'b1;
                elem_left = elem_left - 1'b1;
                if (elem_left == 0) begin
                    if (name_on) begin
                        n = (int'(pos) > MAX_NAME_LEN) ? MAX_NAME_LEN : int'(pos);
                        for (int k = 0; k < n; k++) begin
                            c.ch    = name_mem[k % NAME_DEPTH];
                            c.idx   = NAME_IDX_W'(k);
                            c.len   = NAME_LEN_W'(n);
                            c.bssid = bssid_acc;
                            c.last  = (k + 1 == n);
                            name_chars_due.push_back(c);
                        end
                        name_on = 1'b0;
                        phase   = SCAN_IDLE;
                    end else begin
                        phase = SCAN_ELEM_ID;
                    end
                end
            end
            default: phase = SCAN_IDLE;
        endcase
    endtask

    task automatic check_name_char();
        name_char_t want;
        if (name_chars_due.size() == 0) begin
            flag_mismatch("name word with none expected, ssid_char", m_ssid_char, '0);
            return;
        end
        want = name_chars_due.pop_front();
        if (m_ssid_char !== want.ch)
            flag_mismatch("ssid_char", m_ssid_char, want.ch);
        if (m_char_index !== want.idx)
            flag_mismatch("char_index", m_char_index, want.idx);
        if (m_ssid_length !== want.len)
            flag_mismatch("ssid_length", m_ssid_length, want.len);
        if (m_bssid !== want.bssid)
            flag_mismatch("bssid", m_bssid, want.bssid);
        if (m_last !== want.last)
            flag_mismatch("last", m_last, want.last);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase       = SCAN_IDLE;
            pos         = '0;
            hdr_len_acc = '0;
            bssid_acc   = '0;
            elem_id     = '0;
            elem_left   = '0;
            name_on     = 1'b0;
            name_chars_due.delete();
        end else begin
            // outputs first: a word taken at this edge cannot answer this edge's input
            if (m_valid && m_ready)
                check_name_char();
            if (s_valid && s_ready)
                parse_byte(s_data_byte, s_start_of_frame);
        end
        chars_due <= name_chars_due.size();
    end

endmodule

FILE: verif/tb_beacon_ssid_extractor_core.sv
// testbench top: drives captured frames into the beacon ssid extractor and gives the verdict
module tb_beacon_ssid_extractor_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bse_pkg::*;

    localparam int MAX_NAME_LEN   = 32;
    localparam int POSITION_WIDTH = 16;

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte      = 8'h00;
    logic        s_start_of_frame = 1'b0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [7:0]  m_ssid_char;
    logic [4:0]  m_char_index;
    logic [5:0]  m_ssid_length;
    logic [47:0] m_bssid;
    logic        m_last;

    int          mismatch_count;
    int          chars_due;

    logic [7:0]  frame_bytes [$];
    int          burst_left    = 0;
    int          words_sent    = 0;
    logic [7:0]  stall_mask    = 8'hFF;
    int          stall_timer   = 0;

    always #5 aclk = ~aclk;

    beacon_ssid_extractor_core #(
        .MAX_NAME_LEN  (MAX_NAME_LEN),
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_start_of_frame(s_start_of_frame),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ssid_char     (m_ssid_char),
        .m_char_index    (m_char_index),
        .m_ssid_length   (m_ssid_length),
        .m_bssid         (m_bssid),
        .m_last          (m_last)
    );

    bse_name_checker #(
        .MAX_NAME_LEN  (MAX_NAME_LEN),
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_start_of_frame(s_start_of_frame),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ssid_char     (m_ssid_char),
        .m_char_index    (m_char_index),
        .m_ssid_length   (m_ssid_length),
        .m_bssid         (m_bssid),
        .m_last          (m_last),
        .mismatch_count  (mismatch_count),
        .chars_due       (chars_due)
    );

    // receiver stalls on a rotating mask, reloaded now and then; never all zero
    always @(posedge aclk) begin
        if (stall_timer == 0) begin
            stall_timer <= $urandom_range(16, 80);
            stall_mask  <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        end else begin
            stall_timer <= stall_timer - 1;
            stall_mask  <= {stall_mask[0], stall_mask[7:1]};
        end
        m_ready <= stall_mask[0];
    end

    task automatic send_word(input logic [7:0] b, input logic sof);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        s_valid          <= 1'b1;
        s_data_byte      <= b;
        s_start_of_frame <= sof;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        words_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_word(frame_bytes[i], i == 0);
        frame_bytes.delete();
    endtask

    task automatic send_noise(input int count);
        repeat (count) send_word(8'($urandom), 1'b0);
    endtask

    task automatic push_random(input int count);
        repeat (count) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic push_radiotap(input logic [15:0] rt_len);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(rt_len[7:0]);
        frame_bytes.push_back(rt_len[15:8]);
        if (rt_len > HDR_LEN_MIN)
            push_random(int'(rt_len) - HDR_LEN_MIN);
    endtask

    // frame control byte, then the rest of the mac header and the fixed fields
    task automatic push_mac(input logic [7:0] fc);
        frame_bytes.push_back(fc);
        push_random(ELEMENTS_START - 1);
    endtask

    task automatic push_element(input logic [7:0] id, input int len);
        frame_bytes.push_back(id);
        frame_bytes.push_back(8'(len));
        push_random(len);
    endtask

    task automatic push_filler_elements(input int count);
        repeat (count) begin
            if ($urandom_range(0, 4) == 0)
                push_element(SSID_ELEMENT, ($urandom_range(0, 1) == 0) ? 0 :
                             $urandom_range(MAX_NAME_LEN + 1, 80));
            else
                push_element(8'($urandom_range(1, 255)), $urandom_range(0, 20));
        end
    endtask

    task automatic build_beacon(input logic [15:0] rt_len, input int name_len,
                                input int fillers);
        push_radiotap(rt_len);
        push_mac({BEACON_SUBTYPE, MGMT_TYPE, 2'($urandom)});
        push_filler_elements(fillers);
        push_element(SSID_ELEMENT, name_len);
    endtask

    function automatic logic [7:0] non_beacon_fc();
        logic [7:0] fc;
        do
            fc = 8'($urandom);
        while (fc[3:2] == MGMT_TYPE && fc[7:4] == BEACON_SUBTYPE);
        return fc;
    endfunction

    task automatic run_directed();
        logic [7:0] bad_fc [6];
        bad_fc = '{8'h84, 8'h88, 8'h8C, 8'h90, 8'h00, 8'hF0};
        // bytes while idle are dropped
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        // smallest header, unusable name elements skipped, then a full-length name
        push_radiotap(16'(HDR_LEN_MIN));
        push_mac({BEACON_SUBTYPE, MGMT_TYPE, 2'b11});
        push_element(SSID_ELEMENT, 0);
        push_element(SSID_ELEMENT, MAX_NAME_LEN + 1);
        push_element(8'hFF, 0);
        frame_bytes.push_back(SSID_ELEMENT);
        frame_bytes.push_back(8'(MAX_NAME_LEN));
        for (int k = 0; k < MAX_NAME_LEN; k++)
            frame_bytes.push_back((k == 0) ? 8'h00 :
                                  (k == MAX_NAME_LEN - 1) ? 8'hFF : 8'($urandom));
        send_frame();
        // radiotap length below the minimum
        for (int l = 0; l < HDR_LEN_MIN; l++) begin
            push_radiotap(16'(l));
            push_random(2);
            send_frame();
        end
        // not a beacon: the rest of the frame is ignored
        foreach (bad_fc[i]) begin
            push_radiotap(16'(HDR_LEN_MIN));
            frame_bytes.push_back(bad_fc[i]);
            push_random(4);
            send_frame();
        end
        // frame cut short inside the name, the next frame starts over
        build_beacon(16'd12, 10, 0);
        repeat (3) void'(frame_bytes.pop_back());
        send_frame();
    endtask

    initial begin
        int         kind;
        int         name_len;
        int         cut;
        logic [15:0] rt_len;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        while (words_sent < 320) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                rt_len = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(256, 264)) :
                                                        16'($urandom_range(4, 40));
                case ($urandom_range(0, 3))
                    0:       name_len = 1;
                    1:       name_len = MAX_NAME_LEN;
                    default: name_len = $urandom_range(1, MAX_NAME_LEN);
                endcase
                build_beacon(rt_len, name_len, $urandom_range(0, 3));
                if ($urandom_range(0, 7) == 0) begin
                    // the next frame start abandons this one
                    cut = $urandom_range(1, frame_bytes.size() - 1);
                    while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
                end
                if ($urandom_range(0, 1) == 0)
                    push_random($urandom_range(1, 4));
                send_frame();
            end else if (kind < 72) begin
                push_radiotap(16'($urandom_range(4, 24)));
                push_mac(non_beacon_fc());
                push_filler_elements($urandom_range(0, 2));
                push_element(SSID_ELEMENT, $urandom_range(1, MAX_NAME_LEN));
                send_frame();
            end else if (kind < 82) begin
                push_radiotap(16'($urandom_range(0, HDR_LEN_MIN - 1)));
                push_random($urandom_range(0, 40));
                send_frame();
            end else if (kind < 90) begin
                send_noise($urandom_range(1, 8));
            end else begin
                push_random($urandom_range(1, 60));
                send_frame();
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (chars_due != 0) @(posedge aclk);
        repeat (2 * MAX_NAME_LEN + 8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: beacon_ssid_extractor_core.f
+incdir+sv
sv/bse_pkg.sv
sv/bse_parser.sv
sv/beacon_ssid_extractor_core.sv
verif/bse_name_checker.sv
verif/tb_beacon_ssid_extractor_core.sv
